// ----- src/tbvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvs_pkg
// Shared types and constants for the two-bone vertex skinning block.
// ----------------------------------------------------------------------------
package tbvs_pkg;

   localparam int DefNumBones = 256;
   localparam int DefFracBits = 16;

   localparam int ReqDataW = 232;
   localparam int RspDataW = 192;

   localparam int WeightBits = 16;
   localparam logic [17:0] WeightOne = 18'd65536;

   localparam int QueueDepth = 4;
   localparam int QPtrW = 2;
   localparam int QCntW = 3;

   localparam int NumVectors = 4;
   localparam int NumComps = 3;

   typedef enum logic {
      FuncLoad = 1'b0,
      FuncSkin = 1'b1
   } func_type;

   typedef logic [NumComps-1:0][31:0] vec_type;

   typedef struct packed {
      logic        vertex;
      logic [7:0]  bone_first;
      logic [7:0]  bone_second;
      logic [1:0]  vector_select;
      logic [16:0] weight;
      logic        first_ok;
      logic        second_ok;
      vec_type     pos;
      vec_type     nrm;
      logic        last;
   } item_type;

   typedef struct packed {
      logic             valid;
      logic [QCntW-1:0] count;
   } queue_stat_type;

   typedef struct packed {
      vec_type pos;
      vec_type nrm;
      logic    last;
   } carry_type;

endpackage

// ----- src/tbvs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvs_front
// Accepts request beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module tbvs_front #(
   parameter int NUM_BONES = tbvs_pkg::DefNumBones
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tbvs_pkg::ReqDataW-1:0]    req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             q_pop,
   output tbvs_pkg::item_type               q_item,
   output tbvs_pkg::queue_stat_type         q_stat
);
   import tbvs_pkg::*;

   localparam logic [8:0] BoneLimit = 9'(NUM_BONES);

   item_type           item_in;
   item_type           q_mem_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   count_ff, count_in;
   logic [16:0]        w_raw;
   logic               push;

   always_comb begin
      w_raw                 = req_tdata[34:18];
      item_in.vertex        = (func_type'(req_tuser) == FuncSkin);
      item_in.bone_first    = req_tdata[7:0];
      item_in.bone_second   = req_tdata[15:8];
      item_in.vector_select = req_tdata[17:16];
      item_in.weight        = (w_raw > WeightOne[16:0]) ? WeightOne[16:0] : w_raw;
      item_in.first_ok      = ({1'b0, req_tdata[7:0]} < BoneLimit);
      item_in.second_ok     = ({1'b0, req_tdata[15:8]} < BoneLimit);
      item_in.pos           = req_tdata[130:35];
      item_in.nrm           = req_tdata[226:131];
      item_in.last          = req_tlast;
   end

   assign req_tready = (count_ff != QCntW'(QueueDepth));
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCntW'(push) - QCntW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign q_item       = q_mem_ff[rd_ptr_ff];
   assign q_stat.valid = (count_ff != '0);
   assign q_stat.count = count_ff;

endmodule

// ----- src/tbvs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvs_back
// Bone palette, matrix blend and transform pipeline with the result register.
// ----------------------------------------------------------------------------
module tbvs_back #(
   parameter int NUM_BONES = tbvs_pkg::DefNumBones,
   parameter int FRAC_BITS = tbvs_pkg::DefFracBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tbvs_pkg::item_type               q_item,
   input  tbvs_pkg::queue_stat_type         q_stat,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tbvs_pkg::RspDataW-1:0]    rsp_tdata,
   output logic                             rsp_tlast
);
   import tbvs_pkg::*;

   localparam int BoneW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
   localparam logic signed [65:0] RoundHalf = 66'sd1 <<< (FRAC_BITS - 1);

   logic adv;

   // stage A: palette read
   vec_type  rd1_ff [NumVectors];
   vec_type  rd2_ff [NumVectors];
   item_type ma_ff;
   logic     va_ff;

   // stage B: blend products
   logic signed [49:0] bp1_ff [NumVectors][NumComps];
   logic signed [49:0] bp2_ff [NumVectors][NumComps];
   carry_type          mb_ff;
   logic               vb_ff;

   // stage C: blended matrix
   logic signed [31:0] m_ff [NumVectors][NumComps];
   carry_type          mc_ff;
   logic               vc_ff;

   // stage D: transform products
   logic signed [63:0] tp_ff [2][NumComps][NumComps];
   logic signed [31:0] t_ff [NumComps];
   logic               ld_ff;
   logic               vd_ff;

   // stage E: result
   logic [RspDataW-1:0] rsp_data_ff;
   logic                rsp_last_ff;
   logic                rsp_valid_ff;

   logic [16:0] wa, wb;

   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = q_stat.valid && adv;

   for (genvar v = 0; v < NumVectors; v++) begin : g_mem
      vec_type mem [NUM_BONES];
      logic    we;

      assign we = q_pop && !q_item.vertex && q_item.first_ok &&
                  (q_item.vector_select == 2'(v));

      always_ff @(posedge clock) begin
         if (we) begin
            mem[q_item.bone_first[BoneW-1:0]] <= q_item.pos;
         end
         if (adv) begin
            rd1_ff[v] <= mem[q_item.bone_first[BoneW-1:0]];
            rd2_ff[v] <= mem[q_item.bone_second[BoneW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_ff <= q_item;
      end
   end

   assign wa = ma_ff.weight;
   assign wb = 17'(WeightOne - {1'b0, ma_ff.weight});

   for (genvar v = 0; v < NumVectors; v++) begin : g_blend
      for (genvar c = 0; c < NumComps; c++) begin : g_comp
         logic signed [31:0] x1, x2;
         logic signed [50:0] s;
         logic signed [31:0] e;

         assign x1 = ma_ff.first_ok  ? $signed(rd1_ff[v][c]) : 32'sd0;
         assign x2 = ma_ff.second_ok ? $signed(rd2_ff[v][c]) : 32'sd0;

         always_ff @(posedge clock) begin
            if (adv) begin
               bp1_ff[v][c] <= x1 * $signed({1'b0, wa});
               bp2_ff[v][c] <= x2 * $signed({1'b0, wb});
            end
         end

         always_comb begin
            s = {bp1_ff[v][c][49], bp1_ff[v][c]} + {bp2_ff[v][c][49], bp2_ff[v][c]}
                + 51'sd32768;
            e = s[47:16];
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               if (c == 0) begin
                  m_ff[v][c] <= (e == 32'sh8000_0000) ? 32'sh7fff_ffff : -e;
               end else begin
                  m_ff[v][c] <= e;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mb_ff.pos  <= ma_ff.pos;
         mb_ff.nrm  <= ma_ff.nrm;
         mb_ff.last <= ma_ff.last;
         mc_ff      <= mb_ff;
         ld_ff      <= mc_ff.last;
         rsp_last_ff <= ld_ff;
      end
   end

   for (genvar c = 0; c < NumComps; c++) begin : g_xform
      for (genvar k = 0; k < NumComps; k++) begin : g_term
         always_ff @(posedge clock) begin
            if (adv) begin
               tp_ff[0][c][k] <= m_ff[k][c] * $signed(mc_ff.pos[k]);
               tp_ff[1][c][k] <= m_ff[k][c] * $signed(mc_ff.nrm[k]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            t_ff[c] <= m_ff[3][c];
         end
      end

      for (genvar o = 0; o < 2; o++) begin : g_out
         logic signed [65:0] acc, acc_sh;
         logic signed [66:0] tot;
         logic        [31:0] res;

         always_comb begin
            acc = {{2{tp_ff[o][c][0][63]}}, tp_ff[o][c][0]}
                + {{2{tp_ff[o][c][1][63]}}, tp_ff[o][c][1]}
                + {{2{tp_ff[o][c][2][63]}}, tp_ff[o][c][2]} + RoundHalf;
            acc_sh = acc >>> FRAC_BITS;
            tot = {acc_sh[65], acc_sh} + {{35{t_ff[c][31]}}, t_ff[c]};
            if (tot > 67'sd2147483647) begin
               res = 32'h7fff_ffff;
            end else if (tot < -67'sd2147483648) begin
               res = 32'h8000_0000;
            end else begin
               res = tot[31:0];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rsp_data_ff[(o*3+c)*32 +: 32] <= res;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         va_ff        <= q_pop && q_item.vertex;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vd_ff        <= vc_ff;
         rsp_valid_ff <= vd_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/two_bone_vertex_skinning.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_bone_vertex_skinning
// Two-bone linear blend skinning of vertex positions and normals.
// ----------------------------------------------------------------------------
// Request beats on req_*: tuser 0 loads one bone vector (three Q16.16 words
// into the palette), tuser 1 skins one vertex. Load beats give no response;
// each vertex beat gives one response beat on rsp_* carrying the position
// and normal, x components negated, tlast copied from the request.
// Beats enter a four-deep queue; the back end pops one beat a cycle unless the
// response stalls, reads both bones from four palette memories (one per vector,
// two read ports), blends (blend products, then blended matrix) and transforms
// (transform products, then the result register). Throughput is one beat per
// cycle while rsp_tready stays high. A load is visible to the very next beat.
// Reset empties the queue and pipeline; the palette holds no reset value and
// bones must be loaded before use.
// While the receiver stalls, the pipeline holds and the queue absorbs up to
// four further request beats before req_tready drops.
// ----------------------------------------------------------------------------
module two_bone_vertex_skinning #(
   parameter int NUM_BONES = tbvs_pkg::DefNumBones,
   parameter int FRAC_BITS = tbvs_pkg::DefFracBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // bone_first, bone_second, vector_select, blend_weight, pos_x, pos_y,
   // pos_z, nrm_x, nrm_y, nrm_z, zero fill
   input  logic [tbvs_pkg::ReqDataW-1:0]    req_tdata,
   input  logic                             req_tuser,  // func
   input  logic                             req_tlast,  // last_vertex
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
   output logic [tbvs_pkg::RspDataW-1:0]    rsp_tdata,
   output logic                             rsp_tlast   // out_last
);
   import tbvs_pkg::*;

   item_type       q_item;
   queue_stat_type q_stat;
   logic           q_pop;

   tbvs_front #(
      .NUM_BONES (NUM_BONES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .q_stat     (q_stat)
   );

   tbvs_back #(
      .NUM_BONES (NUM_BONES),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !q_pop)
      else $error("queue popped while response stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCntW'(QueueDepth))
      else $error("queue count beyond depth");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready == (q_stat.count != QCntW'(QueueDepth)))
      else $error("ready disagrees with queue fill");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !q_pop) |=> q_stat.valid)
      else $error("accepted beat lost from queue");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for two_bone_vertex_skinning: bone vectors are loaded
// into the palette, then vertices are skinned under random bursts and stalls;
// every response beat is checked against an in-bench blend/transform model.
// ----------------------------------------------------------------------------
module testbench;
   import tbvs_pkg::*;

   localparam int NumBones = 256;
   localparam int FracBits = 16;
   localparam int NumRandom = 1500;
   localparam longint CycleLimit = 400000;

   typedef struct {
      func_type   func;
      logic [7:0] bone_a;
      logic [7:0] bone_b;
      logic [1:0] vsel;
      logic [16:0] weight;
      logic [31:0] pos [3];
      logic [31:0] nrm [3];
      logic       last;
   } beat_type;

   typedef struct {
      logic [31:0] pos [3];
      logic [31:0] nrm [3];
      logic        last;
   } skinned_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic rsp_tlast;

   beat_type    pending_beats [$];
   skinned_type expected_vertices [$];
   logic [31:0] palette [NumBones*12];
   int          errors = 0;
   longint      cycles = 0;
   bit          hold_off = 1'b0;
   bit          stim_done = 1'b0;

   two_bone_vertex_skinning dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint floor_div(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint palette_word(logic [7:0] bone, int idx);
      if (bone >= NumBones) return 0;
      return longint'(signed'(palette[bone*12 + idx]));
   endfunction

   function automatic logic [31:0] apply_matrix(longint m [12], logic [31:0] v [3], int c);
      longint hi, lo, p, h;
      hi = 0;
      lo = 0;
      for (int k = 0; k < 3; k++) begin
         p = m[k*3 + c] * longint'(signed'(v[k]));
         h = floor_div(p, FracBits);
         hi += h;
         lo += p - (h <<< FracBits);
      end
      hi += floor_div(lo + (64'sd1 <<< (FracBits - 1)), FracBits);
      return 32'(clamp32(hi + m[9 + c]));
   endfunction

   // Updates the palette model; returns 1 with the predicted vertex on skin beats.
   function automatic bit skin_vertex(beat_type b, output skinned_type r);
      longint m [12];
      longint w, s, e;
      if (b.func == FuncLoad) begin
         if (b.bone_a < NumBones) begin
            for (int i = 0; i < 3; i++) begin
               palette[b.bone_a*12 + b.vsel*3 + i] = b.pos[i];
            end
         end
         return 1'b0;
      end
      w = (b.weight > 65536) ? 65536 : b.weight;
      for (int i = 0; i < 12; i++) begin
         s = palette_word(b.bone_a, i) * w + palette_word(b.bone_b, i) * (65536 - w);
         e = floor_div(s + 32768, 16);
         if (i % 3 == 0) e = (e == -64'sd2147483648) ? 64'sd2147483647 : -e;
         m[i] = e;
      end
      for (int c = 0; c < 3; c++) begin
         r.pos[c] = apply_matrix(m, b.pos, c);
         r.nrm[c] = apply_matrix(m, b.nrm, c);
      end
      r.last = b.last;
      return 1'b1;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
      endcase
   endfunction

   function automatic beat_type load_beat(int bone, int vsel, bit extreme);
      beat_type b;
      b.func = FuncLoad;
      b.bone_a = 8'(bone);
      b.bone_b = 8'($urandom);
      b.vsel = 2'(vsel);
      b.weight = 17'($urandom);
      b.last = 1'($urandom);
      for (int i = 0; i < 3; i++) begin
         b.pos[i] = extreme ? rand_word() : 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
         b.nrm[i] = $urandom;
      end
      return b;
   endfunction

   function automatic beat_type skin_beat(int bone_a, int bone_b);
      beat_type b;
      b.func = FuncSkin;
      b.bone_a = 8'(bone_a);
      b.bone_b = 8'(bone_b);
      b.vsel = 2'($urandom);
      case ($urandom_range(0, 5))
         0: b.weight = 17'd0;
         1: b.weight = 17'd65536;
         2: b.weight = 17'($urandom_range(65537, 131071));
         default: b.weight = 17'($urandom_range(0, 65536));
      endcase
      b.last = 1'($urandom);
      for (int i = 0; i < 3; i++) begin
         b.pos[i] = rand_word();
         b.nrm[i] = rand_word();
      end
      return b;
   endfunction

   initial begin
      beat_type b;
      int ba, bb;
      // a few bones fully loaded, including extreme values
      for (int bone = 0; bone < 4; bone++)
         for (int v = 0; v < 4; v++) pending_beats.push_back(load_beat(bone, v, bone >= 2));
      b = load_beat(255, 0, 1'b0);
      pending_beats.push_back(b);
      b = skin_beat(0, 1);
      b.weight = 17'd0;
      pending_beats.push_back(b);
      b = skin_beat(2, 3);
      b.weight = 17'd65536;
      pending_beats.push_back(b);
      b = skin_beat(3, 2);
      b.weight = 17'h1ffff;
      pending_beats.push_back(b);
      b = skin_beat(2, 3);
      for (int i = 0; i < 3; i++) begin
         b.pos[i] = 32'h8000_0000;
         b.nrm[i] = 32'h7fff_ffff;
      end
      pending_beats.push_back(b);
      b = skin_beat(1, 0);
      b.last = 1'b1;
      pending_beats.push_back(b);
      for (int n = 0; n < NumRandom; n++) begin
         if ($urandom_range(0, 9) < 2) begin
            pending_beats.push_back(load_beat($urandom_range(0, 255), $urandom_range(0, 3),
                                              $urandom_range(0, 3) == 0));
         end else begin
            // only bones with all four vectors loaded are read
            ba = $urandom_range(0, 3);
            bb = $urandom_range(0, 3);
            pending_beats.push_back(skin_beat(ba, bb));
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts and gaps; prediction on every accepted request beat
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      skinned_type r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (skin_vertex(pending_beats[0], r)) expected_vertices.push_back(r);
            void'(pending_beats.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_beats[0].func;
               req_tlast <= pending_beats[0].last;
               req_tdata <= {5'd0, pending_beats[0].nrm[2], pending_beats[0].nrm[1],
                  pending_beats[0].nrm[0], pending_beats[0].pos[2], pending_beats[0].pos[1],
                  pending_beats[0].pos[0], pending_beats[0].weight, pending_beats[0].vsel,
                  pending_beats[0].bone_b, pending_beats[0].bone_a};
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
               stim_done <= 1'b1;
            end
         end
      end
   end

   // receiver stall pattern plus one long hold-off
   int hold_count = 0;
   always @(posedge clock) begin
      if (!reset && cycles == 400) hold_count <= 300;
      else if (hold_count > 0) hold_count <= hold_count - 1;
      hold_off <= (hold_count > 1);
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else if ((cycles / 200) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // monitor
   always @(posedge clock) begin
      skinned_type exp_v;
      logic [31:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vertices.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_v = expected_vertices.pop_front();
            for (int c = 0; c < 6; c++) begin
               got = rsp_tdata[c*32 +: 32];
               if (got !== (c < 3 ? exp_v.pos[c] : exp_v.nrm[c-3])) begin
                  $display("%0t: field %0d expected %h actual %h", $time, c,
                           (c < 3 ? exp_v.pos[c] : exp_v.nrm[c-3]), got);
                  errors++;
               end
            end
            if (rsp_tlast !== exp_v.last) begin
               $display("%0t: tlast expected %b actual %b", $time, exp_v.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("two_bone_vertex_skinning verification failed");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_vertices.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_vertices.size() == 0) begin
         $display("two_bone_vertex_skinning verification clean");
      end else begin
         $display("two_bone_vertex_skinning verification failed");
      end
      $finish;
   end

endmodule
